// ===== rtl/assert_macros.svh =====
// Assertion macros used by the interpolator controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/pwli_pkg.sv =====
// Types, constants and command codes of the piecewise linear interpolator.
`timescale 1ns / 1ps
package pwli_pkg;

    localparam int DATA_W    = 32;
    localparam int MAX_KNOTS = 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int DIV_W     = 65;
    localparam int DVSR_W    = 33;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    localparam logic [CNT_W-1:0] KNOT_MIN = 7'd2;
    localparam logic [CNT_W-1:0] KNOT_MAX = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM    = 1'b1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] knot_position;
        logic signed [DATA_W-1:0] knot_sample;
        logic signed [DATA_W-1:0] query_point;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] interpolated;
        logic signed [DATA_W-1:0] slope;
        logic [IDX_W-1:0]         segment;
        logic                     zero_width;
    } t_out;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_RK0,
        OP_RKN2,
        OP_RKN1,
        OP_IDX_ZERO,
        OP_IDX_LAST,
        OP_UDIV_START,
        OP_UDIV_END,
        OP_BS_INIT,
        OP_BS_ADDR,
        OP_BS_CMP,
        OP_IDX_LO,
        OP_RD_I,
        OP_RD_J,
        OP_DIFF,
        OP_ABS,
        OP_MUL,
        OP_MUL2,
        OP_ZW_RES,
        OP_SDIV_START,
        OP_SDIV_END,
        OP_VDIV_START,
        OP_VDIV_END,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic below;
        logic above;
        logic uniform;
        logic span_pos;
        logic bs_done;
        logic zw;
        logic div_done;
    } t_sts;

endpackage

// ===== rtl/pwli_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module pwli_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pwli_pkg::DIV_W-1:0]       i_dividend,
    input  logic [pwli_pkg::DVSR_W-1:0]      i_divisor,
    output logic                             o_done,
    output logic [pwli_pkg::DIV_W-1:0]       o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [6:0]                     r_cnt;
    logic [pwli_pkg::DIV_W-1:0]     r_quo;
    logic [pwli_pkg::DVSR_W-1:0]    r_rem;
    logic [pwli_pkg::DVSR_W-1:0]    r_dvsr;
    logic [pwli_pkg::DVSR_W:0]      w_trial;
    logic                           w_fit;

    // remainder stays below the divisor, so one extra bit covers the shift
    assign w_trial = {r_rem, r_quo[pwli_pkg::DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dvsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(pwli_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[pwli_pkg::DIV_W-2:0], w_fit};
            r_rem <= w_fit ? pwli_pkg::DVSR_W'(w_trial - {1'b0, r_dvsr})
                           : w_trial[pwli_pkg::DVSR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== rtl/pwli_dpath.sv =====
// Datapath: knot and sample tables, segment search registers and arithmetic.
`timescale 1ns / 1ps
module pwli_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pwli_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pwli_pkg::CFG_W-1:0]          i_cfg_data,
    input  pwli_pkg::t_in                       i_in,
    input  pwli_pkg::t_cmd                      i_cmd,
    output pwli_pkg::t_sts                      o_sts,
    output pwli_pkg::t_out                      o_out
);

    localparam int W  = pwli_pkg::DATA_W;
    localparam int IW = pwli_pkg::IDX_W;

    logic [pwli_pkg::CNT_W-1:0] r_cfg_cnt;
    logic                       r_cfg_uni;

    logic signed [W-1:0] knot_mem [pwli_pkg::MAX_KNOTS];
    logic signed [W-1:0] samp_mem [pwli_pkg::MAX_KNOTS];
    logic signed [W-1:0] r_rk;
    logic signed [W-1:0] r_rv;

    logic signed [W-1:0] r_x, r_k0, r_kn2, r_ki, r_vi, r_slope, r_val;
    logic signed [W:0]   r_xk0, r_span, r_dx, r_dv, r_p;
    logic                r_below, r_above, r_zw, r_sneg, r_vneg;
    logic [W+6:0]        r_uprod;
    logic [IW-1:0]       r_lo, r_hi, r_mid, r_idx;
    logic [W:0]          r_mdx, r_mdv, r_mp;
    logic [2*W-1:0]      r_plo;
    logic [pwli_pkg::DIV_W-1:0] r_prod;
    pwli_pkg::t_out      r_out;

    logic [pwli_pkg::CNT_W-1:0] w_n;
    logic [IW-1:0]              w_nm2, w_nm1, w_mid, w_raddr;
    logic [IW:0]                w_mid_sum;
    logic                       w_div_start, w_div_done, w_big;
    logic [pwli_pkg::DIV_W-1:0] w_dividend, w_quo;
    logic [pwli_pkg::DVSR_W-1:0] w_divisor;
    logic signed [35:0]         w_sum;
    logic [35:0]                w_qext;

    // knot count outside 2..64 acts as the nearest bound
    always_comb begin
        if (r_cfg_cnt < pwli_pkg::KNOT_MIN) begin
            w_n = pwli_pkg::KNOT_MIN;
        end else if (r_cfg_cnt > pwli_pkg::KNOT_MAX) begin
            w_n = pwli_pkg::KNOT_MAX;
        end else begin
            w_n = r_cfg_cnt;
        end
    end
    assign w_nm2     = IW'(w_n - 7'd2);
    assign w_nm1     = IW'(w_n - 7'd1);
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + 7'd1;
    assign w_mid     = w_mid_sum[IW:1];

    always_comb begin
        case (i_cmd.op)
            pwli_pkg::OP_START:   w_raddr = '0;
            pwli_pkg::OP_RK0:     w_raddr = w_nm2;
            pwli_pkg::OP_RKN2:    w_raddr = w_nm1;
            pwli_pkg::OP_BS_ADDR: w_raddr = w_mid;
            pwli_pkg::OP_RD_J:    w_raddr = r_idx + 6'd1;
            default:              w_raddr = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cnt <= pwli_pkg::KNOT_MIN;
            r_cfg_uni <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pwli_pkg::CFG_KNOT_COUNT: r_cfg_cnt <= i_cfg_data;
                pwli_pkg::CFG_UNIFORM:    r_cfg_uni <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == pwli_pkg::OP_LOAD) begin
            knot_mem[i_in.entry_index] <= i_in.knot_position;
            samp_mem[i_in.entry_index] <= i_in.knot_sample;
        end
        r_rk <= knot_mem[w_raddr];
        r_rv <= samp_mem[w_raddr];
    end

    always_comb begin
        case (i_cmd.op)
            pwli_pkg::OP_UDIV_START: begin
                w_dividend = {26'd0, r_uprod};
                w_divisor  = r_span;
            end
            pwli_pkg::OP_SDIV_START: begin
                w_dividend = {16'd0, r_mdv, 16'd0};
                w_divisor  = r_mdx;
            end
            default: begin
                w_dividend = r_prod;
                w_divisor  = r_mdx;
            end
        endcase
    end
    assign w_div_start = (i_cmd.op == pwli_pkg::OP_UDIV_START) ||
                         (i_cmd.op == pwli_pkg::OP_SDIV_START) ||
                         (i_cmd.op == pwli_pkg::OP_VDIV_START);

    pwli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // quotients of 2^34 and up saturate whatever the left sample is
    assign w_big  = |w_quo[pwli_pkg::DIV_W-1:34];
    assign w_qext = {2'b00, w_quo[33:0]};
    assign w_sum  = $signed({{4{r_vi[W-1]}}, r_vi}) +
                    $signed(r_vneg ? 36'(-w_qext) : w_qext);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            pwli_pkg::OP_START: r_x <= i_in.query_point;
            pwli_pkg::OP_RK0: begin
                r_k0  <= r_rk;
                r_xk0 <= (W+1)'(r_x) - (W+1)'(r_rk);
            end
            pwli_pkg::OP_RKN2: r_kn2 <= r_rk;
            pwli_pkg::OP_RKN1: begin
                r_span  <= (W+1)'(r_rk) - (W+1)'(r_k0);
                r_below <= r_xk0[W];
                r_above <= (r_x > r_kn2);
                r_uprod <= (W+7)'(r_xk0) * (W+7)'(w_nm1);
            end
            pwli_pkg::OP_IDX_ZERO: r_idx <= '0;
            pwli_pkg::OP_IDX_LAST: r_idx <= w_nm2;
            pwli_pkg::OP_UDIV_END: begin
                r_idx <= ((|w_quo[pwli_pkg::DIV_W-1:IW]) || (w_quo[IW-1:0] > w_nm2))
                         ? w_nm2 : w_quo[IW-1:0];
            end
            pwli_pkg::OP_BS_INIT: begin
                r_lo <= '0;
                r_hi <= w_nm2;
            end
            pwli_pkg::OP_BS_ADDR: r_mid <= w_mid;
            pwli_pkg::OP_BS_CMP: begin
                if (r_rk <= r_x) begin
                    r_lo <= r_mid;
                end else begin
                    r_hi <= r_mid - 6'd1;
                end
            end
            pwli_pkg::OP_IDX_LO: r_idx <= r_lo;
            pwli_pkg::OP_RD_J: begin
                r_ki <= r_rk;
                r_vi <= r_rv;
            end
            pwli_pkg::OP_DIFF: begin
                r_dx <= (W+1)'(r_rk) - (W+1)'(r_ki);
                r_dv <= (W+1)'(r_rv) - (W+1)'(r_vi);
                r_p  <= (W+1)'(r_x) - (W+1)'(r_ki);
            end
            pwli_pkg::OP_ABS: begin
                r_mdx  <= r_dx[W] ? (W+1)'(-r_dx) : r_dx;
                r_mdv  <= r_dv[W] ? (W+1)'(-r_dv) : r_dv;
                r_mp   <= r_p[W] ? (W+1)'(-r_p) : r_p;
                r_zw   <= (r_dx == '0);
                r_sneg <= r_dv[W] ^ r_dx[W];
                r_vneg <= r_p[W] ^ r_dv[W] ^ r_dx[W];
            end
            pwli_pkg::OP_MUL: r_plo <= r_mp[W-1:0] * r_mdv[W-1:0];
            pwli_pkg::OP_MUL2: begin
                // a magnitude with its top bit set is exactly 2^32
                if (r_mp[W]) begin
                    r_prod <= {r_mdv, 32'd0};
                end else if (r_mdv[W]) begin
                    r_prod <= {r_mp, 32'd0};
                end else begin
                    r_prod <= {1'b0, r_plo};
                end
            end
            pwli_pkg::OP_ZW_RES: begin
                r_slope <= '0;
                r_val   <= r_vi;
            end
            pwli_pkg::OP_SDIV_END: begin
                if (r_sneg) begin
                    r_slope <= (w_quo > 65'h80000000) ? 32'sh80000000 : W'(-w_quo);
                end else begin
                    r_slope <= (w_quo > 65'h7FFFFFFF) ? 32'sh7FFFFFFF : W'(w_quo);
                end
            end
            pwli_pkg::OP_VDIV_END: begin
                if (w_big) begin
                    r_val <= r_vneg ? 32'sh80000000 : 32'sh7FFFFFFF;
                end else if (w_sum > 36'sh07FFFFFFF) begin
                    r_val <= 32'sh7FFFFFFF;
                end else if (w_sum < -36'sh080000000) begin
                    r_val <= 32'sh80000000;
                end else begin
                    r_val <= W'(w_sum);
                end
            end
            pwli_pkg::OP_OUT: begin
                r_out.interpolated <= r_val;
                r_out.slope        <= r_slope;
                r_out.segment      <= r_idx;
                r_out.zero_width   <= r_zw;
            end
            default: ;
        endcase
    end

    assign o_sts.below    = r_below;
    assign o_sts.above    = r_above;
    assign o_sts.uniform  = r_cfg_uni;
    assign o_sts.span_pos = !r_span[W] && (r_span != '0);
    assign o_sts.bs_done  = (r_lo == r_hi);
    assign o_sts.zw       = r_zw;
    assign o_sts.div_done = w_div_done;
    assign o_out          = r_out;

endmodule

// ===== rtl/pwli_ctrl.sv =====
// Controller: sequences loads and evaluations and owns both handshakes.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pwli_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_action,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pwli_pkg::t_sts  i_sts,
    output pwli_pkg::t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_RK0, S_RKN2, S_RKN1, S_CLASS, S_UWAIT, S_BS, S_BSCMP,
        S_RDI, S_RDJ, S_DIFF, S_ABS, S_MUL, S_MUL2, S_CHK, S_SWAIT,
        S_VSTART, S_VWAIT, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op    = pwli_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == pwli_pkg::ACT_EVAL) begin
                        o_cmd.op = pwli_pkg::OP_START;
                        n_state  = S_RK0;
                    end else begin
                        o_cmd.op = pwli_pkg::OP_LOAD;
                    end
                end
            end
            S_RK0: begin
                o_cmd.op = pwli_pkg::OP_RK0;
                n_state  = S_RKN2;
            end
            S_RKN2: begin
                o_cmd.op = pwli_pkg::OP_RKN2;
                n_state  = S_RKN1;
            end
            S_RKN1: begin
                o_cmd.op = pwli_pkg::OP_RKN1;
                n_state  = S_CLASS;
            end
            S_CLASS: begin
                if (i_sts.below) begin
                    o_cmd.op = pwli_pkg::OP_IDX_ZERO;
                    n_state  = S_RDI;
                end else if (i_sts.above) begin
                    o_cmd.op = pwli_pkg::OP_IDX_LAST;
                    n_state  = S_RDI;
                end else if (i_sts.uniform) begin
                    if (i_sts.span_pos) begin
                        o_cmd.op = pwli_pkg::OP_UDIV_START;
                        n_state  = S_UWAIT;
                    end else begin
                        o_cmd.op = pwli_pkg::OP_IDX_ZERO;
                        n_state  = S_RDI;
                    end
                end else begin
                    o_cmd.op = pwli_pkg::OP_BS_INIT;
                    n_state  = S_BS;
                end
            end
            S_UWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.op = pwli_pkg::OP_UDIV_END;
                    n_state  = S_RDI;
                end
            end
            S_BS: begin
                if (i_sts.bs_done) begin
                    o_cmd.op = pwli_pkg::OP_IDX_LO;
                    n_state  = S_RDI;
                end else begin
                    o_cmd.op = pwli_pkg::OP_BS_ADDR;
                    n_state  = S_BSCMP;
                end
            end
            S_BSCMP: begin
                o_cmd.op = pwli_pkg::OP_BS_CMP;
                n_state  = S_BS;
            end
            S_RDI: begin
                o_cmd.op = pwli_pkg::OP_RD_I;
                n_state  = S_RDJ;
            end
            S_RDJ: begin
                o_cmd.op = pwli_pkg::OP_RD_J;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.op = pwli_pkg::OP_DIFF;
                n_state  = S_ABS;
            end
            S_ABS: begin
                o_cmd.op = pwli_pkg::OP_ABS;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = pwli_pkg::OP_MUL;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = pwli_pkg::OP_MUL2;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (i_sts.zw) begin
                    o_cmd.op = pwli_pkg::OP_ZW_RES;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = pwli_pkg::OP_SDIV_START;
                    n_state  = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.op = pwli_pkg::OP_SDIV_END;
                    n_state  = S_VSTART;
                end
            end
            S_VSTART: begin
                o_cmd.op = pwli_pkg::OP_VDIV_START;
                n_state  = S_VWAIT;
            end
            S_VWAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.op = pwli_pkg::OP_VDIV_END;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.op    = pwli_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `AST_NXT(a_eval_starts, (r_state == S_IDLE) && i_in_valid && (i_action == pwli_pkg::ACT_EVAL), r_state == S_RK0)
    `AST_IMP(a_done_in_wait, i_sts.div_done, (r_state == S_UWAIT) || (r_state == S_SWAIT) || (r_state == S_VWAIT))
    `AST_NXT(a_out_loaded, (r_state == S_OUT) && !r_out_valid, r_out_valid && (r_state == S_IDLE))

endmodule

// ===== rtl/piecewise_linear_interpolator.sv =====
// Top level of the piecewise linear interpolator (signed Q16.16).
`timescale 1ns / 1ps
// A load beat writes one knot and its sample into the tables at entry_index
// and yields no result. An evaluate beat yields one result beat: the value
// on the chosen segment's line, the segment slope (saturated), the left knot
// index and a zero-width flag. Queries below the first knot use the first
// segment, queries above knot n-2 extrapolate the last segment; between, the
// segment comes from a binary search (up to six probes) or, with
// uniform_spacing set, from a divide. All divides share one bit-serial
// divider of 65 steps. An evaluate divides for the slope and the value, and
// with uniform spacing a third divide picks the segment. A zero-width
// segment skips the slope and value divides. The input side takes a new
// beat only between evaluations; a finished result sits in the output
// register, so the next beat is taken while it waits. Knots must be loaded
// in ascending order; configuration must be written only while the block
// is idle, which the block itself does not enforce.
module piecewise_linear_interpolator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pwli_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pwli_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pwli_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pwli_pkg::t_out                     o_out
);

    pwli_pkg::t_cmd w_cmd;   // one datapath operation per cycle
    pwli_pkg::t_sts w_sts;   // compare flags and divider done

    pwli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in.action),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    pwli_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (o_out)
    );

endmodule

// ===== tb/tb_piecewise_linear_interpolator.sv =====
// Testbench for the piecewise linear interpolator: random and directed beats, scoreboard check.
`timescale 1ns / 1ps
module tb_piecewise_linear_interpolator;

    localparam longint S32_MIN   = -64'sd2147483648;
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam int     LIMIT     = 1500000;
    localparam int     SETTLE    = 20;

    // Scoreboard: keeps its own copy of the tables and registers, predicts the
    // result of each evaluate beat and checks results in order.
    class interp_scoreboard;
        longint knots[64];
        longint samples[64];
        logic [pwli_pkg::CNT_W-1:0] knot_count_reg;
        bit   uniform_reg;
        pwli_pkg::t_out pending[$];
        int   errors;
        int   loads;
        int   evals;
        int   checked;

        function void reset_regs();
            knot_count_reg = pwli_pkg::KNOT_MIN;
            uniform_reg = 0;
            foreach (knots[i]) begin
                knots[i] = 0;
                samples[i] = 0;
            end
        endfunction

        function void write_reg(logic [pwli_pkg::CFG_IDX_W-1:0] idx,
                                logic [pwli_pkg::CFG_W-1:0] d);
            if (idx == pwli_pkg::CFG_KNOT_COUNT) knot_count_reg = d;
            else uniform_reg = d[0];
        endfunction

        function longint mag(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint sat32(longint v);
            return v > S32_MAX ? S32_MAX : (v < S32_MIN ? S32_MIN : v);
        endfunction

        function void note_input(pwli_pkg::t_in it);
            longint n, x, idx, lo, hi, mid, span, ki, kj, vi, vj, dx, dv, p, s, slope, val;
            bit [127:0] prod, q;
            bit zw;
            pwli_pkg::t_out e;
            if (it.action == pwli_pkg::ACT_LOAD) begin
                knots[it.entry_index] = it.knot_position;
                samples[it.entry_index] = it.knot_sample;
                loads++;
                return;
            end
            evals++;
            n = knot_count_reg;
            if (n < 2) n = 2;
            if (n > pwli_pkg::MAX_KNOTS) n = pwli_pkg::MAX_KNOTS;
            x = it.query_point;
            zw = 0;
            if (x < knots[0]) begin
                idx = 0;
            end else if (x > knots[n-2]) begin
                idx = n - 2;
            end else if (uniform_reg) begin
                span = knots[n-1] - knots[0];
                if (span <= 0) idx = 0;
                else idx = (x - knots[0]) * (n - 1) / span;
                if (idx > n - 2) idx = n - 2;
            end else begin
                // search for the rightmost knot not above the query
                lo = 0;
                hi = n - 2;
                while (lo < hi) begin
                    mid = (lo + hi + 1) / 2;
                    if (knots[mid] <= x) lo = mid;
                    else hi = mid - 1;
                end
                idx = lo;
            end
            ki = knots[idx];
            kj = knots[idx+1];
            vi = samples[idx];
            vj = samples[idx+1];
            dx = kj - ki;
            dv = vj - vi;
            if (dx == 0) begin
                zw = 1;
                slope = 0;
                val = vi;
            end else begin
                s = (mag(dv) << 16) / mag(dx);
                slope = sat32(((dv < 0) != (dx < 0)) ? -s : s);
                p = x - ki;
                prod = 128'(mag(p)) * 128'(mag(dv));
                q = prod / 128'(mag(dx));
                if (q > (128'd1 << 40)) q = 128'd1 << 40;
                s = longint'(q[63:0]);
                val = sat32(vi + ((((p < 0) != (dv < 0)) != (dx < 0)) ? -s : s));
            end
            e.interpolated = val[31:0];
            e.slope = slope[31:0];
            e.segment = idx[pwli_pkg::IDX_W-1:0];
            e.zero_width = zw;
            pending.push_back(e);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(pwli_pkg::t_out got);
            pwli_pkg::t_out e;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("result beat with nothing expected: %h", got));
                return;
            end
            e = pending.pop_front();
            if (got.interpolated !== e.interpolated)
                report($sformatf("interpolated got %h exp %h", got.interpolated,
                                 e.interpolated));
            if (got.slope !== e.slope)
                report($sformatf("slope got %h exp %h", got.slope, e.slope));
            if (got.segment !== e.segment)
                report($sformatf("segment got %0d exp %0d", got.segment, e.segment));
            if (got.zero_width !== e.zero_width)
                report($sformatf("zero_width got %b exp %b", got.zero_width,
                                 e.zero_width));
        endtask
    endclass

    logic                           i_clk = 0;
    logic                           i_rst_n = 0;
    logic                           i_cfg_we = 0;
    logic [pwli_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [pwli_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                           i_in_valid = 0;
    logic                           o_in_ready;
    pwli_pkg::t_in                  i_in = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 0;
    pwli_pkg::t_out                 o_out;

    interp_scoreboard sb = new();
    bit  calm = 0;
    int  cycles = 0;

    piecewise_linear_interpolator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check every accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
    end

    // result side stalls in bursts, none once calm is set
    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                i_out_ready <= 1;
            end
        end
    end

    // one input beat; valid stays up afterwards until the next beat or a drop
    task automatic send_beat(pwli_pkg::t_in it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1;
        i_in <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 0;
    endtask

    // unused fields carry random bits
    task automatic load_entry(int e, longint k, longint v);
        pwli_pkg::t_in it;
        it = '0;
        it.query_point = $urandom;
        it.action = pwli_pkg::ACT_LOAD;
        it.entry_index = pwli_pkg::IDX_W'(e);
        it.knot_position = k[31:0];
        it.knot_sample = v[31:0];
        send_beat(it);
    endtask

    task automatic eval_at(longint x);
        pwli_pkg::t_in it;
        it = '0;
        it.entry_index = pwli_pkg::IDX_W'($urandom);
        it.knot_position = $urandom;
        it.knot_sample = $urandom;
        it.action = pwli_pkg::ACT_EVAL;
        it.query_point = x[31:0];
        send_beat(it);
    endtask

    // register writes only with the block drained
    task automatic write_reg(logic [pwli_pkg::CFG_IDX_W-1:0] idx,
                             logic [pwli_pkg::CFG_W-1:0] d);
        drop_valid();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, d);
    endtask

    function automatic longint rand_between(longint lo, longint hi);
        bit [63:0] r;
        r = {$urandom, $urandom};
        return lo + longint'(r % 64'(hi - lo + 1));
    endfunction

    function automatic longint rand_sample();
        case ($urandom_range(0, 3))
            0: return rand_between(-1000000, 1000000);
            1: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
            default: return rand_between(S32_MIN, S32_MAX);
        endcase
    endfunction

    // fill all 64 entries; kind picks the knot layout
    // 0 equal spacing, 1 ascending with repeats, 2 full-range extremes,
    // 3 unordered, 4 flat (all knots equal)
    task automatic fill_table(int kind);
        longint k, step, gap;
        longint ks[64];
        k = 0;
        step = 1;
        case (kind)
            0: begin
                step = $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(1, 1 << 24);
                k = rand_between(S32_MIN, S32_MAX - 63 * step);
            end
            1: k = rand_between(S32_MIN, -64'sd1000000);
            2: k = S32_MIN;
            4: k = rand_between(S32_MIN, S32_MAX);
            default: ;
        endcase
        for (int e = 0; e < 64; e++) begin
            ks[e] = k;
            case (kind)
                0: k = k + step;
                1, 2: begin
                    case ($urandom_range(0, 7))
                        0: gap = 0;
                        1, 2, 3: gap = $urandom_range(1, 255);
                        default: gap = $urandom_range(1, 1 << 25);
                    endcase
                    k = k + gap;
                    if (k > S32_MAX) k = S32_MAX;
                end
                3: k = rand_between(S32_MIN, S32_MAX);
                default: ;
            endcase
        end
        if (kind == 2) ks[63] = S32_MAX;
        for (int e = 0; e < 64; e++) begin
            if (kind == 2) load_entry(e, ks[e], (e % 2) ? S32_MAX : S32_MIN);
            else load_entry(e, ks[e], rand_sample());
        end
    endtask

    function automatic longint sat_q(longint v);
        return v > S32_MAX ? S32_MAX : (v < S32_MIN ? S32_MIN : v);
    endfunction

    function automatic longint pick_query();
        longint n, lo, hi;
        n = sb.knot_count_reg;
        if (n < 2) n = 2;
        if (n > pwli_pkg::MAX_KNOTS) n = pwli_pkg::MAX_KNOTS;
        lo = sb.knots[0];
        hi = sb.knots[n-1];
        if (hi < lo) begin
            hi = lo;
            lo = sb.knots[n-1];
        end
        case ($urandom_range(0, 9))
            0: return rand_between(S32_MIN, S32_MAX);
            1, 2: return sb.knots[$urandom_range(0, n - 1)];
            3: return sat_q(sb.knots[$urandom_range(0, n - 1)] + rand_between(-4, 4));
            4: return $urandom_range(0, 1) ? S32_MIN : S32_MAX;
            5: return rand_between(S32_MIN, lo);
            6: return rand_between(hi, S32_MAX);
            default: return rand_between(lo, hi);
        endcase
    endfunction

    task automatic run_phase(int cnt, int uni, int kind, int queries);
        write_reg(pwli_pkg::CFG_KNOT_COUNT, cnt[pwli_pkg::CFG_W-1:0]);
        write_reg(pwli_pkg::CFG_UNIFORM, uni[pwli_pkg::CFG_W-1:0]);
        fill_table(kind);
        for (int q = 0; q < queries; q++) begin
            // now and then rewrite one sample; knot order stays intact
            if ($urandom_range(0, 9) == 0) begin
                int e;
                e = $urandom_range(0, 63);
                load_entry(e, sb.knots[e], rand_sample());
            end
            eval_at(pick_query());
        end
    endtask

    initial begin
        sb.reset_regs();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: two-knot tables, zero width, saturation, query extremes
        write_reg(pwli_pkg::CFG_KNOT_COUNT, 7'd2);
        write_reg(pwli_pkg::CFG_UNIFORM, 7'd0);
        load_entry(0, 0, 100);
        load_entry(1, 0, -5);
        eval_at(0);
        eval_at(S32_MIN);
        eval_at(S32_MAX);
        load_entry(0, 0, S32_MIN);
        load_entry(1, 1, S32_MAX);
        eval_at(0);
        eval_at(1);
        eval_at(-1);
        eval_at(S32_MIN);
        eval_at(S32_MAX);
        load_entry(1, 65536, -65536);
        eval_at(32768);
        eval_at(-65536);
        write_reg(pwli_pkg::CFG_UNIFORM, 7'd1);
        eval_at(0);
        eval_at(65535);
        eval_at(S32_MAX);

        // random phases over register settings, extremes included
        run_phase(64, 1, 0, 60);
        run_phase(64, 0, 1, 65);
        run_phase(2, 1, 1, 40);
        run_phase(127, 0, 2, 65);
        run_phase(0, 1, 3, 50);
        run_phase(10, 1, 4, 40);
        run_phase(33, 1, 1, 60);
        run_phase(17, 0, 3, 60);
        run_phase(1, 0, 0, 30);
        calm = 1;
        run_phase(64, 1, 0, 60);
        drop_valid();

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("covered %0d load beats and %0d evaluate beats, %0d results checked",
                 sb.loads, sb.evals, sb.checked);
        $display("knot counts 0..127, both segment modes, ordered, flat and unordered tables");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            if (sb.pending.size() != 0)
                $display("%0d expected results never arrived", sb.pending.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule
